@@ src/frp_pkg.sv @@
package frp_pkg;

   localparam int FRAMES  = 64;
   localparam int FRAME_W = 6;
   localparam int CNT_W   = 7;
   localparam int PID_W   = 6;
   localparam int PAGE_W  = 6;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic              func;
      logic [PID_W-1:0]  pid;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [FRAME_W-1:0] frame;
      logic [CNT_W-1:0]   freed_count;
      logic [CNT_W-1:0]   free_frames;
   } rsp_type;

endpackage

@@ src/frp_ram.sv @@
module frp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/frame_pool_allocator.sv @@
// Physical frame pool allocator. A request beat with func = allocate pops the
// head of the free list and returns that frame (status EMPTY with frame 0 when
// no frame is free); func = free-all walks every frame in ascending order and
// pushes each frame owned by pid back onto the head of the free list, so the
// highest such frame is handed out next. Every response carries the free-frame
// count after the request. The head entry of the free stack is read on the
// accept edge, and an allocate registers its response once the response
// register can take it. A free-all sweeps the owner table, which has a single
// read port, one entry per cycle, and registers its response once the walk is
// done, the last compare has drained and the response register can take it.
// The block returns to idle on the edge that registers the response, so a new
// request is accepted only once the previous response has been registered.
// Only one request is in flight: req_stall stays high from accept until the
// response has been written to the output register, and also while a csr write
// is offered. A new request may be accepted while that response still waits on
// rsp_stall, in which case the next response waits for that one to leave.
// Writing the csr port (only while idle) rebuilds the pool with
// min(csr_data, 64) frames; all frames become free and ownership is forgotten.
// After reset the pool holds 64 frames.
// The page field is accepted but not stored, as no response depends on it.
module frame_pool_allocator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  frp_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output frp_pkg::rsp_type         rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [frp_pkg::CNT_W-1:0] csr_data
);

   import frp_pkg::*;

   // sequencer codes
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ALLOC  = 2'd1;
   localparam logic [1:0] ST_SWEEP  = 2'd2;

   logic [1:0]         state_ff, state_in;

   // free list bookkeeping
   logic [CNT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [FRAMES-1:0]  stack_vld_ff, stack_vld_in;   // stack entry written since setup
   logic [FRAMES-1:0]  in_use_ff, in_use_in;

   // latched request
   logic [PID_W-1:0]   pid_ff, pid_in;

   // sweep: idx drives the owner read, chk/chk_idx is the compare stage
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               chk_ff, chk_in;
   logic [FRAME_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]   freed_ff, freed_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // RAM ports
   logic               stk_we;
   logic [FRAME_W-1:0] stk_waddr;
   logic [FRAME_W-1:0] stk_q;
   logic               own_we;
   logic [FRAME_W-1:0] own_waddr;
   logic [PID_W-1:0]   own_q;

   logic               slot_free;
   logic               req_acc;
   logic               csr_acc;
   logic [FRAME_W-1:0] head_idx;
   logic [FRAME_W-1:0] alloc_frame;
   logic               hit;

   // Free stack: always reading the head entry, so the data is ready the
   // cycle after an allocate is accepted. Entries never written read as
   // their own index.
   frp_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (chk_idx_ff),
      .rd_addr (head_idx),
      .rd_data (stk_q)
   );

   // Owner pid table, read by the free-all sweep.
   frp_ram #(.WIDTH(PID_W), .DEPTH(FRAMES)) u_owner (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (pid_ff),
      .rd_addr (idx_ff[FRAME_W-1:0]),
      .rd_data (own_q)
   );

   assign head_idx    = head_ff[FRAME_W-1:0];
   assign alloc_frame = stack_vld_ff[head_idx] ? stk_q : head_idx;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   // a pending csr write wins the idle cycle, so hold requests off meanwhile
   assign req_stall   = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready   = (state_ff == ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign csr_acc     = csr_valid && csr_ready;

   // a frame to release: in use, owned by pid, and the list has room below head
   assign hit = chk_ff && in_use_ff[chk_idx_ff] && (own_q == pid_ff) &&
                (head_ff != '0);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      stack_vld_in = stack_vld_ff;
      in_use_in    = in_use_ff;
      pid_in       = pid_ff;
      idx_in       = idx_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      freed_in     = freed_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      stk_we       = 1'b0;
      stk_waddr    = head_idx - FRAME_W'(1);
      own_we       = 1'b0;
      own_waddr    = alloc_frame;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               head_in      = '0;
               total_in     = (csr_data > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : csr_data;
               stack_vld_in = '0;
               in_use_in    = '0;
            end else if (req_acc) begin
               pid_in   = req_data.pid;
               idx_in   = '0;
               chk_in   = 1'b0;
               freed_in = '0;
               state_in = (req_data.func == FUNC_FREE) ? ST_SWEEP : ST_ALLOC;
            end
         end

         ST_ALLOC: begin
            // commit only once the response register can take the beat
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.freed_count = '0;
               if (total_ff == '0) begin
                  rsp_in.status      = STATUS_EMPTY;
                  rsp_in.frame       = '0;
                  rsp_in.free_frames = total_ff;
               end else begin
                  own_we                 = 1'b1;
                  in_use_in[alloc_frame] = 1'b1;
                  head_in                = head_ff + CNT_W'(1);
                  total_in               = total_ff - CNT_W'(1);
                  rsp_in.status          = STATUS_OK;
                  rsp_in.frame           = alloc_frame;
                  rsp_in.free_frames     = total_ff - CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_SWEEP: begin
            if (idx_ff != CNT_W'(FRAMES)) begin
               idx_in     = idx_ff + CNT_W'(1);
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[FRAME_W-1:0];
            end else begin
               chk_in = 1'b0;
            end

            if (hit) begin
               // push the frame onto the head of the free list
               stk_we                  = 1'b1;
               stack_vld_in[stk_waddr] = 1'b1;
               in_use_in[chk_idx_ff]   = 1'b0;
               head_in                 = head_ff - CNT_W'(1);
               total_in                = total_ff + CNT_W'(1);
               freed_in                = freed_ff + CNT_W'(1);
            end

            // walk done and last compare drained
            if ((idx_ff == CNT_W'(FRAMES)) && !chk_ff && slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = STATUS_OK;
               rsp_in.frame       = '0;
               rsp_in.freed_count = freed_ff;
               rsp_in.free_frames = total_ff;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         total_ff     <= CNT_W'(FRAMES);
         stack_vld_ff <= '0;
         in_use_ff    <= '0;
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         freed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         stack_vld_ff <= stack_vld_in;
         in_use_ff    <= in_use_in;
         idx_ff       <= idx_in;
         chk_ff       <= chk_in;
         freed_ff     <= freed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pid_ff     <= pid_in;
      chk_idx_ff <= chk_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import frp_pkg::*;

   // Stimulus table rows: either a csr write of frame_count or a request beat.
   typedef enum logic { ROW_REQ, ROW_CFG } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [6:0]   cfg;
      req_type      req;
      bit           pinned;   // expected response typed in below, not predicted
      rsp_type      want;
   } plan_row_type;

   localparam int QUIET_LIMIT  = 2000;   // cycles with no beat moving anywhere
   localparam int RANDOM_ITEMS = 1230;
   localparam int PHASE_LEN    = 160;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CNT_W-1:0] csr_data = '0;

   // Shadow copy of the frame pool.
   logic [FRAME_W-1:0] pool_stack [FRAMES];
   logic [PID_W-1:0]   frame_owner [FRAMES];
   bit                 frame_busy [FRAMES];
   int                 pool_head;
   int                 pool_free;

   rsp_type      rsp_owed_q[$];     // responses still to come, oldest first
   plan_row_type plan[$];
   bit           pin_on  = 1'b0;
   rsp_type      pin_rsp = '0;
   bit           calm    = 1'b0;    // no idling on either side while set
   int           mismatches  = 0;
   int           quiet_cycles = 0;

   frame_pool_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Set-up: frames 0..n-1 free in ascending order, everything else forgotten.
   // Counts above the pool size saturate.
   function automatic void rebuild_pool(logic [6:0] n);
      for (int i = 0; i < FRAMES; i++) begin
         pool_stack[i] = FRAME_W'(i);
         frame_busy[i] = 1'b0;
      end
      pool_head = 0;
      pool_free = (int'(n) > FRAMES) ? FRAMES : int'(n);
   endfunction

   // Apply one request to the shadow pool and return the response it earns.
   function automatic rsp_type pool_step(req_type r);
      rsp_type            p;
      logic [FRAME_W-1:0] f;
      p = '0;
      p.status = STATUS_OK;
      if (r.func == FUNC_ALLOC) begin
         if (pool_free == 0 || pool_head >= FRAMES) begin
            p.status = STATUS_EMPTY;
         end else begin
            f = pool_stack[pool_head];
            pool_head++;
            pool_free--;
            frame_busy[f]  = 1'b1;
            frame_owner[f] = r.pid;
            p.frame = f;
         end
      end else begin
         // ascending sweep, each hit pushed on the head: highest hit ends on top
         for (int i = 0; i < FRAMES; i++) begin
            if (frame_busy[i] && frame_owner[i] == r.pid && pool_head > 0) begin
               frame_busy[i] = 1'b0;
               pool_head--;
               pool_stack[pool_head] = FRAME_W'(i);
               pool_free++;
               p.freed_count = p.freed_count + CNT_W'(1);
            end
         end
      end
      p.free_frames = CNT_W'(pool_free);
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge. Response side first so a
   // response and the next request beat in the same cycle pair up correctly.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      bit      moved;
      moved = 1'b0;
      if (reset) begin
         rebuild_pool(7'd64);
      end else begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (rsp_owed_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected rsp beat, got status=%0d frame=%0d freed=%0d free=%0d",
                        $time, rsp_data.status, rsp_data.frame,
                        rsp_data.freed_count, rsp_data.free_frames);
            end else begin
               want = rsp_owed_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.frame !== want.frame ||
                   rsp_data.freed_count !== want.freed_count ||
                   rsp_data.free_frames !== want.free_frames) begin
                  mismatches++;
                  $display("%0t: rsp mismatch, expected status=%0d frame=%0d freed=%0d free=%0d",
                           $time, want.status, want.frame, want.freed_count,
                           want.free_frames);
                  $display("%0t:                    got status=%0d frame=%0d freed=%0d free=%0d",
                           $time, rsp_data.status, rsp_data.frame,
                           rsp_data.freed_count, rsp_data.free_frames);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            rebuild_pool(csr_data);
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want = pool_step(req_data);
            rsp_owed_q.push_back(pin_on ? pin_rsp : want);
         end
      end

      // watchdog: any beat moving resets it
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver back-pressure, changed only at the falling edge.
   always @(negedge clock) begin
      rsp_stall = !calm && ($urandom_range(99) < 25);
   end

   // ---------------------------------------------------------------------
   // Drivers. Each starts at a falling edge; issue_req returns right after the
   // rising edge that took the beat, leaving valid high so back-to-back beats
   // never drop it.
   // ---------------------------------------------------------------------
   task automatic issue_req(req_type r, bit pinned, rsp_type want);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 25) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      pin_on    = pinned;
      pin_rsp   = want;
      do @(posedge clock); while (req_stall);
   endtask

   // Sender holds off until every owed response is back and the block is idle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (rsp_owed_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_frame_count(logic [6:0] n);
      wait_drained();
      csr_valid = 1'b1;
      csr_data  = n;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic plan_row_type make_row(row_kind_type kind, logic [6:0] cfg,
                                             logic func, int pid, int page, bit pinned,
                                             logic status, int frame, int freed,
                                             int free_left);
      plan_row_type r;
      r.kind             = kind;
      r.cfg              = cfg;
      r.req.func         = func;
      r.req.pid          = PID_W'(pid);
      r.req.page         = PAGE_W'(page);
      r.pinned           = pinned;
      r.want.status      = status;
      r.want.frame       = FRAME_W'(frame);
      r.want.freed_count = CNT_W'(freed);
      r.want.free_frames = CNT_W'(free_left);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int         phase;
      logic [6:0] size;
      req_type    r;

      // Directed table. Rows with pinned = 1 carry a hand-written response;
      // the rest are checked against the predictor.
      //                     kind     cfg    func        pid page pin status      frm frd free
      // fresh pool of 64: ascending hand-out, max pid/page
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC,  0,  0, 1, STATUS_OK,    0, 0, 63));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC, 63, 63, 1, STATUS_OK,    1, 0, 62));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC,  5, 21, 0, STATUS_OK,    0, 0,  0));
      // free-all of a pid that owns nothing
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,  42,  0, 1, STATUS_OK,    0, 0, 61));
      // released frame goes back on the head and is reused first
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,   0,  0, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC,  1, 42, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,  63,  0, 0, STATUS_OK,    0, 0,  0));
      // set-up while frames are in use, pool of one
      plan.push_back(make_row(ROW_CFG, 7'd1, FUNC_ALLOC,  0,  0, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC,  5,  1, 1, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC,  5,  2, 1, STATUS_EMPTY, 0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,   1,  0, 1, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,   5,  0, 1, STATUS_OK,    0, 1,  1));
      // empty pool
      plan.push_back(make_row(ROW_CFG, 7'd0, FUNC_ALLOC,  0,  0, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC,  9, 12, 1, STATUS_EMPTY, 0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,   9,  0, 1, STATUS_OK,    0, 0,  0));
      // pool of three, multi-frame free-all, highest freed frame comes out next
      plan.push_back(make_row(ROW_CFG, 7'd3, FUNC_ALLOC,  0,  0, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC, 10,  7, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC, 11, 50, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC, 10, 33, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,  10,  0, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC, 12, 18, 0, STATUS_OK,    0, 0,  0));
      // oversized count saturates to the full pool
      plan.push_back(make_row(ROW_CFG, 7'd127, FUNC_ALLOC, 0, 0, 0, STATUS_OK,    0, 0,  0));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_ALLOC, 31, 45, 1, STATUS_OK,    0, 0, 63));
      plan.push_back(make_row(ROW_REQ, 7'd0, FUNC_FREE,  31,  0, 1, STATUS_OK,    0, 1, 64));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CFG)
            write_frame_count(plan[k].cfg);
         else
            issue_req(plan[k].req, plan[k].pinned, plan[k].want);
      end

      // Random part: phases of pool sizes, extremes included. Mostly allocs
      // across a handful of pids so free-alls find work; a slice of requests
      // uses the full pid range.
      phase = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            case (phase % 8)
               0:       size = 7'd1;
               1:       size = 7'd64;
               2:       size = 7'($urandom_range(8, 2));
               3:       size = 7'd0;
               4:       size = 7'd127;
               5:       size = 7'($urandom_range(127, 1));
               6:       size = 7'($urandom_range(16, 3));
               default: size = 7'd64;
            endcase
            write_frame_count(size);
            phase++;
         end
         calm = (n >= 480 && n < 720);
         // sender stops and lets the pipe empty out mid-phase
         if (n == 900) wait_drained();

         r.func = ($urandom_range(99) < 22) ? FUNC_FREE : FUNC_ALLOC;
         r.pid  = ($urandom_range(99) < 85) ? PID_W'($urandom_range(3, 0))
                                            : PID_W'($urandom_range(63, 0));
         r.page = PAGE_W'($urandom_range(63, 0));
         issue_req(r, 1'b0, '0);
      end

      @(negedge clock);
      req_valid = 1'b0;
      calm = 1'b0;
      while (rsp_owed_q.size() != 0) @(negedge clock);
      repeat (FRAMES + 8) @(posedge clock);

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
